>>> rtl/lkc_pkg.sv
// ---------------------------------------------------------------------------
// lkc_pkg: shared types and constants of the lru key cache
// Field widths, operation codes, cell commands and controller states.
// ---------------------------------------------------------------------------
package lkc_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int REF_BITS_DEF = 16;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int NREF_W  = 16;
  localparam int SID_W   = 8;
  localparam int FILL_W  = 5;
  localparam int STAMP_W = 32;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_PURGE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_TOUCH,
    CM_WRITE,
    CM_MARK,
    CM_SHIFT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       by_server;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_COMPACT
  } ctl_state_t;

endpackage

>>> rtl/lkc_cell.sv
// ---------------------------------------------------------------------------
// lkc_cell: one record of the lru key cache
// Holds key, handle, server id and stamp, compares against the query,
// and passes the running oldest-stamp and hit results to the next cell.
// ---------------------------------------------------------------------------
module lkc_cell #(
  parameter int KEY_BITS = lkc_pkg::KEY_BITS_DEF,
  parameter int REF_BITS = lkc_pkg::REF_BITS_DEF,
  parameter int IDX_W    = 4
) (
  input  logic                      clk,
  input  lkc_pkg::cell_cmd_t        cmd,
  input  logic                      valid,
  input  logic                      is_slot,
  input  logic [IDX_W-1:0]          cell_idx,
  input  logic [KEY_BITS-1:0]       q_key,
  input  logic [REF_BITS-1:0]       q_ref,
  input  logic [lkc_pkg::SID_W-1:0] q_sid,
  input  logic [lkc_pkg::STAMP_W-1:0] q_stamp,
  // record of the neighbor at the next higher index
  input  logic                      up_keep,
  input  logic [KEY_BITS-1:0]       up_key,
  input  logic [REF_BITS-1:0]       up_ref,
  input  logic [lkc_pkg::SID_W-1:0] up_srv,
  input  logic [lkc_pkg::STAMP_W-1:0] up_stamp,
  input  logic                      down_keep,
  output logic                      keep,
  output logic [KEY_BITS-1:0]       ent_key,
  output logic [REF_BITS-1:0]       ent_ref,
  output logic [lkc_pkg::SID_W-1:0] ent_srv,
  output logic [lkc_pkg::STAMP_W-1:0] ent_stamp,
  output logic                      match,
  // oldest-stamp chain
  input  logic [lkc_pkg::STAMP_W-1:0] min_stamp_in,
  input  logic [IDX_W-1:0]          min_idx_in,
  output logic [lkc_pkg::STAMP_W-1:0] min_stamp_out,
  output logic [IDX_W-1:0]          min_idx_out,
  // hit chain
  input  logic                      hit_in,
  input  logic [REF_BITS-1:0]       hit_ref_in,
  input  logic [lkc_pkg::SID_W-1:0] hit_srv_in,
  output logic                      hit_out,
  output logic [REF_BITS-1:0]       hit_ref_out,
  output logic [lkc_pkg::SID_W-1:0] hit_srv_out
);
  import lkc_pkg::*;

  assign match = valid & (cmd.by_server ? (ent_srv == q_sid) : (ent_key == q_key));

  always_ff @(posedge clk) begin
    unique case (cmd.mode)
      CM_HOLD: begin
      end
      CM_TOUCH: begin
        if (match) ent_stamp <= q_stamp;
      end
      CM_WRITE: begin
        if (is_slot) begin
          ent_key   <= q_key;
          ent_ref   <= q_ref;
          ent_srv   <= q_sid;
          ent_stamp <= q_stamp;
        end
      end
      CM_MARK: begin
        keep <= valid & ~match;
      end
      CM_SHIFT: begin
        // holes bubble up, survivors slide down one place per cycle
        if (!keep && up_keep) begin
          ent_key   <= up_key;
          ent_ref   <= up_ref;
          ent_srv   <= up_srv;
          ent_stamp <= up_stamp;
          keep      <= 1'b1;
        end else if (keep && !down_keep) begin
          keep <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // strict compare keeps the lower index on a tie
  always_ff @(posedge clk) begin
    if (ent_stamp < min_stamp_in) begin
      min_stamp_out <= ent_stamp;
      min_idx_out   <= cell_idx;
    end else begin
      min_stamp_out <= min_stamp_in;
      min_idx_out   <= min_idx_in;
    end
    if (match) begin
      hit_out     <= 1'b1;
      hit_ref_out <= ent_ref;
      hit_srv_out <= ent_srv;
    end else begin
      hit_out     <= hit_in;
      hit_ref_out <= hit_ref_in;
      hit_srv_out <= hit_srv_in;
    end
  end

endmodule

>>> rtl/lru_key_cache_with_group_purge.sv
// ---------------------------------------------------------------------------
// lru_key_cache_with_group_purge: fully associative lru key cache
// Row of record cells with lookup, insert, delete by key and purge by server.
// ---------------------------------------------------------------------------
//  channel | direction | signals                    | contents
//  s_      | in        | s_tvalid s_tready s_tdata  | op, key, node_ref, server_id
//  m_      | out       | m_tvalid m_tready m_tdata  | hit, found_ref, found_server, fill
//
//  lookup and insert scan the whole row before their table update: the oldest-stamp
//  and hit results ripple through the ENTRIES cells one register per cycle.
//  delete and purge mark the matches and then run until the holes have bubbled
//  up through the cell row during compaction.
//  rst clears the fill count, the access counter and the controller; no clearing pass.
//  a new transaction is taken only in idle; a stalled result holds the block
//  until the output register frees, lookup and insert before their table update.
// ---------------------------------------------------------------------------
module lru_key_cache_with_group_purge #(
  parameter int ENTRIES  = lkc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lkc_pkg::KEY_BITS_DEF,
  parameter int REF_BITS = lkc_pkg::REF_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // op[1:0], key[33:2], node_ref[49:34], server_id[57:50], zero[63:58]
  input  logic [lkc_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // hit[0], found_ref[16:1], found_server[24:17], fill[29:25], zero[31:30]
  output logic [lkc_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import lkc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  ctl_state_t state, state_next;
  logic [IDX_W-1:0]    scan_cnt;
  op_t                 op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [REF_BITS-1:0] ref_r;
  logic [SID_W-1:0]    sid_r;
  logic [CNT_W-1:0]    count, count_next;
  logic [STAMP_W-1:0]  clock, clock_next;

  cell_cmd_t        cmd;
  logic [IDX_W-1:0] slot;
  logic             full, out_free, out_load, out_hit;
  logic [NREF_W-1:0] out_ref;
  logic [SID_W-1:0] out_srv;
  logic             packed_ok;
  logic [CNT_W-1:0] keep_cnt;
  op_t              s_op;

  logic [ENTRIES-1:0]  c_valid, c_slot, c_keep, c_keep_up, c_keep_dn, c_match, c_hit;
  logic [KEY_BITS-1:0] c_key      [ENTRIES];
  logic [REF_BITS-1:0] c_ref      [ENTRIES];
  logic [SID_W-1:0]    c_srv      [ENTRIES];
  logic [STAMP_W-1:0]  c_stamp    [ENTRIES];
  logic [STAMP_W-1:0]  c_min_stamp[ENTRIES];
  logic [IDX_W-1:0]    c_min_idx  [ENTRIES];
  logic [REF_BITS-1:0] c_hit_ref  [ENTRIES];
  logic [SID_W-1:0]    c_hit_srv  [ENTRIES];

  assign s_op     = op_t'(s_tdata[1:0]);
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign full     = (count == CNT_W'(ENTRIES));
  assign slot     = full ? c_min_idx[ENTRIES-1] : count[IDX_W-1:0];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                up_keep_w;
    logic [KEY_BITS-1:0] up_key_w;
    logic [REF_BITS-1:0] up_ref_w;
    logic [SID_W-1:0]    up_srv_w;
    logic [STAMP_W-1:0]  up_stamp_w;
    logic [STAMP_W-1:0]  min_stamp_w;
    logic [IDX_W-1:0]    min_idx_w;
    logic                hit_w;
    logic [REF_BITS-1:0] hit_ref_w;
    logic [SID_W-1:0]    hit_srv_w;

    assign c_valid[i] = (CNT_W'(i) < count);
    assign c_slot[i]  = (IDX_W'(i) == slot);

    if (i == ENTRIES - 1) begin : g_top
      assign up_keep_w  = 1'b0;
      assign up_key_w   = '0;
      assign up_ref_w   = '0;
      assign up_srv_w   = '0;
      assign up_stamp_w = '0;
    end else begin : g_mid
      assign up_keep_w  = c_keep[i+1];
      assign up_key_w   = c_key[i+1];
      assign up_ref_w   = c_ref[i+1];
      assign up_srv_w   = c_srv[i+1];
      assign up_stamp_w = c_stamp[i+1];
    end

    if (i == 0) begin : g_head
      assign c_keep_dn[i] = 1'b1;
      assign min_stamp_w  = '1;
      assign min_idx_w    = '0;
      assign hit_w        = 1'b0;
      assign hit_ref_w    = '0;
      assign hit_srv_w    = '0;
    end else begin : g_rest
      assign c_keep_dn[i] = c_keep[i-1];
      assign min_stamp_w  = c_min_stamp[i-1];
      assign min_idx_w    = c_min_idx[i-1];
      assign hit_w        = c_hit[i-1];
      assign hit_ref_w    = c_hit_ref[i-1];
      assign hit_srv_w    = c_hit_srv[i-1];
    end

    assign c_keep_up[i] = up_keep_w;

    lkc_cell #(
      .KEY_BITS (KEY_BITS),
      .REF_BITS (REF_BITS),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk           (clk),
      .cmd           (cmd),
      .valid         (c_valid[i]),
      .is_slot       (c_slot[i]),
      .cell_idx      (IDX_W'(i)),
      .q_key         (key_r),
      .q_ref         (ref_r),
      .q_sid         (sid_r),
      .q_stamp       (clock),
      .up_keep       (up_keep_w),
      .up_key        (up_key_w),
      .up_ref        (up_ref_w),
      .up_srv        (up_srv_w),
      .up_stamp      (up_stamp_w),
      .down_keep     (c_keep_dn[i]),
      .keep          (c_keep[i]),
      .ent_key       (c_key[i]),
      .ent_ref       (c_ref[i]),
      .ent_srv       (c_srv[i]),
      .ent_stamp     (c_stamp[i]),
      .match         (c_match[i]),
      .min_stamp_in  (min_stamp_w),
      .min_idx_in    (min_idx_w),
      .min_stamp_out (c_min_stamp[i]),
      .min_idx_out   (c_min_idx[i]),
      .hit_in        (hit_w),
      .hit_ref_in    (hit_ref_w),
      .hit_srv_in    (hit_srv_w),
      .hit_out       (c_hit[i]),
      .hit_ref_out   (c_hit_ref[i]),
      .hit_srv_out   (c_hit_srv[i])
    );
  end

  // packed when no hole sits below a kept record; the last kept cell gives the count
  always_comb begin
    packed_ok = 1'b1;
    keep_cnt  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!c_keep[i] && c_keep_up[i]) packed_ok = 1'b0;
      if (c_keep[i] && !c_keep_up[i]) keep_cnt = keep_cnt | CNT_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
      count    <= '0;
      clock    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      scan_cnt <= (state == ST_SCAN) ? scan_cnt + 1'b1 : '0;
      count    <= count_next;
      clock    <= clock_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r  <= s_op;
      key_r <= KEY_BITS'(s_tdata[33:2]);
      ref_r <= REF_BITS'(s_tdata[49:34]);
      sid_r <= s_tdata[57:50];
    end
    if (out_load) begin
      m_tdata <= {2'b00, FILL_W'(count_next), out_srv, out_ref, out_hit};
    end
  end

  always_comb begin
    state_next    = state;
    cmd.mode      = CM_HOLD;
    cmd.by_server = (op_r == OP_PURGE);
    count_next    = count;
    clock_next    = clock;
    out_load      = 1'b0;
    out_hit       = 1'b0;
    out_ref       = '0;
    out_srv       = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_op == OP_DELETE || s_op == OP_PURGE) ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == IDX_W'(ENTRIES - 1)) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (op_r == OP_DELETE || op_r == OP_PURGE) begin
          cmd.mode   = CM_MARK;
          state_next = ST_COMPACT;
        end else if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          if (c_hit[ENTRIES-1]) begin
            cmd.mode   = CM_TOUCH;
            clock_next = clock + 1'b1;
            out_hit    = 1'b1;
            out_ref    = NREF_W'(c_hit_ref[ENTRIES-1]);
            out_srv    = c_hit_srv[ENTRIES-1];
          end else if (op_r == OP_INSERT) begin
            cmd.mode   = CM_WRITE;
            clock_next = clock + 1'b1;
            if (!full) count_next = count + 1'b1;
          end
        end
      end
      ST_COMPACT: begin
        cmd.mode = CM_SHIFT;
        if (packed_ok && out_free) begin
          count_next = keep_cnt;
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench of the lru key cache with group purge
// Sends lookups, inserts, deletes and purges through the stream ports, with
// random idling on both sides; checks results against a model or fixed values.
// ---------------------------------------------------------------------------
module tb;
  import lkc_pkg::*;

  localparam int SLOTS        = ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 650;
  localparam int CALM_ITEMS   = 80;
  localparam int QUIET_LIMIT  = 5000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 2 * (ENTRIES_DEF + 2) + 8;

  typedef struct packed {
    logic [SID_W-1:0]  sid;
    logic [NREF_W-1:0] nref;
    logic [KEY_W-1:0]  key;
    op_t               op;
  } cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [SID_W-1:0]  fsrv;
    logic [NREF_W-1:0] fref;
    logic              hit;
  } result_t;

  typedef struct {
    cmd_t    cmd;
    bit      typed;
    result_t want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // cache model state
  logic [KEY_W-1:0]   cache_key   [SLOTS];
  logic [NREF_W-1:0]  cache_ref   [SLOTS];
  logic [SID_W-1:0]   cache_sid   [SLOTS];
  logic [STAMP_W-1:0] cache_stamp [SLOTS];
  int                 cache_fill = 0;
  logic [STAMP_W-1:0] access_count = '0;

  result_t expected_q[$];
  int      errors = 0;
  bit      calm = 1'b0;
  bit      hold_now = 1'b0;

  lru_key_cache_with_group_purge uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cmd_t mk(op_t op, logic [KEY_W-1:0] key, logic [NREF_W-1:0] nref,
                              logic [SID_W-1:0] sid);
    cmd_t c;
    c.op   = op;
    c.key  = key;
    c.nref = nref;
    c.sid  = sid;
    return c;
  endfunction

  function automatic result_t res(logic hit, logic [NREF_W-1:0] fref,
                                  logic [SID_W-1:0] fsrv, int fill);
    result_t r;
    r.hit  = hit;
    r.fref = fref;
    r.fsrv = fsrv;
    r.fill = FILL_W'(fill);
    return r;
  endfunction

  // applies one transaction to the cache model and returns its result
  function automatic result_t cache_step(cmd_t c);
    result_t r;
    int      idx;
    int      slot;
    int      w;
    bit      drop;
    r   = '0;
    idx = -1;
    if (c.op == OP_LOOKUP || c.op == OP_INSERT) begin
      for (int i = 0; i < cache_fill; i++)
        if (idx < 0 && cache_key[i] == c.key) idx = i;
      if (idx >= 0) begin
        cache_stamp[idx] = access_count;
        access_count++;
        r.hit  = 1'b1;
        r.fref = cache_ref[idx];
        r.fsrv = cache_sid[idx];
      end else if (c.op == OP_INSERT) begin
        if (cache_fill < SLOTS) begin
          slot = cache_fill;
          cache_fill++;
        end else begin
          // oldest stamp wins, lowest index on a tie
          slot = 0;
          for (int i = 1; i < SLOTS; i++)
            if (cache_stamp[i] < cache_stamp[slot]) slot = i;
        end
        cache_key[slot]   = c.key;
        cache_ref[slot]   = c.nref;
        cache_sid[slot]   = c.sid;
        cache_stamp[slot] = access_count;
        access_count++;
      end
    end else begin
      // remove matches and close the gaps in order
      w = 0;
      for (int i = 0; i < cache_fill; i++) begin
        drop = (c.op == OP_PURGE) ? (cache_sid[i] == c.sid) : (cache_key[i] == c.key);
        if (!drop) begin
          cache_key[w]   = cache_key[i];
          cache_ref[w]   = cache_ref[i];
          cache_sid[w]   = cache_sid[i];
          cache_stamp[w] = cache_stamp[i];
          w++;
        end
      end
      cache_fill = w;
    end
    r.fill = FILL_W'(cache_fill);
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    if (errors < 40)
      $display("mismatch: %s got %0h want %0h at %0t", field, got, want, $time);
    errors++;
  endtask

  // offers one transaction, then records its expected result once taken
  task automatic send_cmd(cmd_t c, bit typed, result_t want);
    result_t predicted;
    s_tdata  <= IN_TDATA_W'(c);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predicted = cache_step(c);
    expected_q.push_back(typed ? want : predicted);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic add_row(ref row_t plan[$], input cmd_t c, input bit typed,
                         input result_t want);
    row_t r;
    r.cmd   = c;
    r.typed = typed;
    r.want  = want;
    plan.push_back(r);
  endtask

  initial begin : stimulus
    row_t             plan[$];
    logic [KEY_W-1:0] key_pool [24];
    logic [SID_W-1:0] sid_pool [4];
    int               span;
    int               pick;
    cmd_t             c;

    foreach (key_pool[i]) key_pool[i] = $urandom;
    foreach (sid_pool[i]) sid_pool[i] = SID_W'($urandom_range(0, 255));

    add_row(plan, mk(OP_LOOKUP, 32'h0, 16'h0, 8'h0), 1'b1, res(0, 0, 0, 0));
    add_row(plan, mk(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF), 1'b1, res(0, 0, 0, 1));
    add_row(plan, mk(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0, 8'h0), 1'b1,
            res(1, 16'hFFFF, 8'hFF, 1));
    // insert of a present key keeps its handle and server
    add_row(plan, mk(OP_INSERT, 32'hFFFF_FFFF, 16'h1234, 8'h12), 1'b1,
            res(1, 16'hFFFF, 8'hFF, 1));
    add_row(plan, mk(OP_INSERT, 32'h0, 16'h0, 8'h0), 1'b1, res(0, 0, 0, 2));
    add_row(plan, mk(OP_DELETE, 32'h5A5A_5A5A, 16'hFFFF, 8'hFF), 1'b1, res(0, 0, 0, 2));
    add_row(plan, mk(OP_DELETE, 32'hFFFF_FFFF, 16'h0, 8'h0), 1'b1, res(0, 0, 0, 1));
    add_row(plan, mk(OP_PURGE, 32'hFFFF_FFFF, 16'hFFFF, 8'h0), 1'b1, res(0, 0, 0, 0));
    for (int i = 0; i < SLOTS; i++)
      add_row(plan, mk(OP_INSERT, 32'hC0DE_0000 + i, NREF_W'(16'h1111 * i),
                       SID_W'(8'h40 + i % 4)), 1'b1, res(0, 0, 0, i + 1));
    // table full: replaces the oldest record
    add_row(plan, mk(OP_INSERT, 32'h0BAD_F00D, 16'hBEEF, 8'h7F), 1'b1,
            res(0, 0, 0, SLOTS));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_cmd(plan[i].cmd, plan[i].typed, plan[i].want);

    span = 17;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       span = 6;
          1:       span = 17;
          default: span = 24;
        endcase
      end
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      if (n == 200) hold_now = 1'b1;
      if (n == 420) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
      end
      pick = $urandom_range(0, 99);
      c.op = (pick < 35) ? OP_LOOKUP : (pick < 75) ? OP_INSERT :
             (pick < 90) ? OP_DELETE : OP_PURGE;
      c.key  = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) :
               key_pool[$urandom_range(0, span - 1)];
      c.nref = NREF_W'($urandom_range(0, 65535));
      c.sid  = ($urandom_range(0, 9) == 0) ? SID_W'($urandom_range(0, 255)) :
               sid_pool[$urandom_range(0, 3)];
      send_cmd(c, 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  initial begin : receiver
    forever begin
      if (hold_now) begin
        // long hold so the block backs up and stalls its input
        hold_now = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (expected_q.size() == 0) begin
        report("unexpected transaction", 32'(got), 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (got.hit !== want.hit)   report("hit", 32'(got.hit), 32'(want.hit));
        if (got.fref !== want.fref) report("found_ref", 32'(got.fref), 32'(want.fref));
        if (got.fsrv !== want.fsrv) report("found_server", 32'(got.fsrv), 32'(want.fsrv));
        if (got.fill !== want.fill) report("fill", 32'(got.fill), 32'(want.fill));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: FAIL");
    $finish;
  end

endmodule
